>>> design/mma_pkg.sv
// Shared types, register codes and arithmetic helpers for merge_mask_into_alpha.
// No dependencies; every other file of the block imports this package.
package mma_pkg;

  localparam int CHAN_W = 8;
  localparam int SIDE_W = 13;
  localparam int REG_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
  localparam logic [CHAN_W-1:0] WHITE_LIMIT = 8'd240;

  // Reciprocal of three in 11 fractional bits; exact for sums of three channels.
  localparam logic [19:0] RECIP3 = 20'd683;
  localparam int RECIP3_SHIFT = 11;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MASK_WIDTH   = 2'd2,
    REG_MASK_HEIGHT  = 2'd3
  } mma_reg_t;

  typedef struct packed {
    logic [SIDE_W-1:0] image_width;
    logic [SIDE_W-1:0] image_height;
    logic [SIDE_W-1:0] mask_width;
    logic [SIDE_W-1:0] mask_height;
  } mma_cfg_t;

  typedef struct packed {
    logic              frame_end;
    logic              mask_used;
    logic [CHAN_W-1:0] mask_blue;
    logic [CHAN_W-1:0] mask_green;
    logic [CHAN_W-1:0] mask_red;
    logic [CHAN_W-1:0] front_blue;
    logic [CHAN_W-1:0] front_green;
    logic [CHAN_W-1:0] front_red;
  } mma_item_t;

  function automatic logic [CHAN_W-1:0] mean3(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c);
    logic [CHAN_W+1:0] sum;
    logic [19:0]       prod;
    sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
    prod = 20'(sum) * RECIP3;
    return prod[RECIP3_SHIFT +: CHAN_W];
  endfunction

endpackage

>>> design/merge_mask_into_alpha.sv
// Top level of merge_mask_into_alpha: registers, front, queue and back part.
// Depends on mma_pkg, mma_regs, mma_front, mma_queue and mma_back.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: front rgb, mask rgb
//   m_axis    out        m_axis_tvalid/tready       tdata: rgb, alpha; tuser; tlast
//   apb       in         psel/penable, pready       four 13-bit size registers
//
// One request is taken per cycle while the queue has room; each accepted request is
// written into the queue and then into the output register.
// The two-entry queue lets the input keep flowing while the output is stalled, until
// both entries are full. Reset clears the scan counters and the queue and sets every size
// register to 1.
module merge_mask_into_alpha import mma_pkg::*; #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // front_red, front_green, front_blue, mask_red, mask_green, mask_blue
  input  logic [47:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]           m_axis_tdata,
  // mask_used
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  mma_cfg_t          cfg;
  mma_item_t         push_item, head;
  logic              push, q_ready, q_valid, pop;
  logic [CHAN_W-1:0] out_red, out_green, out_blue, out_alpha;

  mma_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mma_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .front_red   (s_axis_tdata[7:0]),
    .front_green (s_axis_tdata[15:8]),
    .front_blue  (s_axis_tdata[23:16]),
    .mask_red    (s_axis_tdata[31:24]),
    .mask_green  (s_axis_tdata[39:32]),
    .mask_blue   (s_axis_tdata[47:40]),
    .q_ready     (q_ready),
    .q_push      (push),
    .q_item      (push_item)
  );

  assign s_axis_tready = q_ready;

  mma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  mma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .mask_used (m_axis_tuser),
    .frame_end (m_axis_tlast)
  );

  assign m_axis_tdata = {out_alpha, out_blue, out_green, out_red};

endmodule

>>> design/mma_regs.sv
// Configuration register file of merge_mask_into_alpha with its APB-style port.
// Depends on mma_pkg for the register codes and the configuration struct.
module mma_regs import mma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output mma_cfg_t              cfg
);

  mma_reg_t         sel;
  logic             wr_en;
  logic [SIDE_W-1:0] rd_val;

  assign sel    = mma_reg_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= SIDE_W'(1);
      cfg.image_height <= SIDE_W'(1);
      cfg.mask_width   <= SIDE_W'(1);
      cfg.mask_height  <= SIDE_W'(1);
    end else if (wr_en) begin
      unique case (sel)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[SIDE_W-1:0];
        REG_MASK_WIDTH:   cfg.mask_width   <= pwdata[SIDE_W-1:0];
        REG_MASK_HEIGHT:  cfg.mask_height  <= pwdata[SIDE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_IMAGE_WIDTH:  rd_val = cfg.image_width;
      REG_IMAGE_HEIGHT: rd_val = cfg.image_height;
      REG_MASK_WIDTH:   rd_val = cfg.mask_width;
      REG_MASK_HEIGHT:  rd_val = cfg.mask_height;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_val);

endmodule

>>> design/mma_front.sv
// Front part of merge_mask_into_alpha: scan position counters and classification.
// Depends on mma_pkg; feeds requests into mma_queue.
module mma_front import mma_pkg::*; #(
  parameter int MAX_SIDE = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  mma_cfg_t  cfg,
  input  logic      in_valid,
  input  logic [CHAN_W-1:0] front_red,
  input  logic [CHAN_W-1:0] front_green,
  input  logic [CHAN_W-1:0] front_blue,
  input  logic [CHAN_W-1:0] mask_red,
  input  logic [CHAN_W-1:0] mask_green,
  input  logic [CHAN_W-1:0] mask_blue,
  input  logic      q_ready,
  output logic      q_push,
  output mma_item_t q_item
);

  localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW = (CW + 1 > SIDE_W) ? CW + 1 : SIDE_W;
  localparam logic [SW-1:0] SIDE_LIMIT = SW'(MAX_SIDE);

  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] row_count, row_count_next;
  logic [SW-1:0] width_eff, height_eff;
  logic [SW-1:0] col_inc, row_inc;
  logic [SW-1:0] image_w, image_h;
  logic          used, row_end, frame_end;

  function automatic logic [SW-1:0] eff_side(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) r = SW'(1);
    else if (v > SIDE_LIMIT) r = SIDE_LIMIT;
    return r;
  endfunction

  assign image_w    = SW'(cfg.image_width);
  assign image_h    = SW'(cfg.image_height);
  assign width_eff  = eff_side(image_w);
  assign height_eff = eff_side(image_h);
  assign col_inc    = SW'(column_count) + SW'(1);
  assign row_inc    = SW'(row_count) + SW'(1);
  assign row_end    = col_inc >= width_eff;
  assign frame_end  = row_end && (row_inc >= height_eff);
  assign used       = (SW'(column_count) < SW'(cfg.mask_width)) &&
                      (SW'(row_count) < SW'(cfg.mask_height));

  assign q_push = in_valid && q_ready;

  always_comb begin
    q_item.front_red   = front_red;
    q_item.front_green = front_green;
    q_item.front_blue  = front_blue;
    q_item.mask_red    = used ? mask_red   : CHAN_MAX;
    q_item.mask_green  = used ? mask_green : CHAN_MAX;
    q_item.mask_blue   = used ? mask_blue  : CHAN_MAX;
    q_item.mask_used   = used;
    q_item.frame_end   = frame_end;
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (q_push) begin
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = frame_end ? '0 : row_inc[CW-1:0];
      end else begin
        column_count_next = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

>>> design/mma_queue.sv
// Two-entry queue of classified requests between the front and back parts.
// Depends on mma_pkg for the request struct.
module mma_queue import mma_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mma_item_t push_item,
  output logic      ready,
  input  logic      pop,
  output logic      valid,
  output mma_item_t head
);

  mma_item_t  entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;

  assign ready = count != 2'd2;
  assign valid = count != 2'd0;
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

>>> design/mma_back.sv
// Back part of merge_mask_into_alpha: alpha arithmetic and the output register.
// Depends on mma_pkg for the request struct and the mean3 helper.
module mma_back import mma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mma_item_t         q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_alpha,
  output logic              mask_used,
  output logic              frame_end
);

  logic [CHAN_W-1:0] mask_mean, front_mean, mask_term;
  logic [CHAN_W:0]   alpha_sum;
  logic [CHAN_W-1:0] alpha;
  logic              white;

  assign mask_mean  = mean3(q_head.mask_red, q_head.mask_green, q_head.mask_blue);
  assign front_mean = mean3(q_head.front_red, q_head.front_green, q_head.front_blue);
  assign white      = (q_head.mask_red > WHITE_LIMIT) && (q_head.mask_green > WHITE_LIMIT)
                      && (q_head.mask_blue > WHITE_LIMIT);
  assign mask_term  = white ? '0 : CHAN_MAX - mask_mean;
  assign alpha_sum  = {1'b0, mask_term} + {1'b0, front_mean};
  assign alpha      = alpha_sum[CHAN_W] ? CHAN_MAX : alpha_sum[CHAN_W-1:0];

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_red   <= q_head.front_red;
      out_green <= q_head.front_green;
      out_blue  <= q_head.front_blue;
      out_alpha <= alpha;
      mask_used <= q_head.mask_used;
      frame_end <= q_head.frame_end;
    end
  end

endmodule

>>> tb/sv/tb_merge_mask_into_alpha.sv
// Self-checking testbench for merge_mask_into_alpha: predicts colour, alpha, mask use and
// frame end for every accepted request and compares each result as it leaves the block.
// Depends on mma_pkg and the merge_mask_into_alpha RTL.
module tb_merge_mask_into_alpha;
  import mma_pkg::*;

  localparam int SIDE_LIMIT = 4096;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              mask_used;
    logic              frame_end;
  } pixel_out_t;

  class alpha_scoreboard;
    mma_cfg_t    sizes;
    logic [11:0] column_count;
    logic [11:0] row_count;
    pixel_out_t  awaited_pixels[$];
    int unsigned errors;

    function new();
      sizes = '{default: SIDE_W'(1)};
      column_count = '0;
      row_count = '0;
      errors = 0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v);
      if (v == '0) return SIDE_W'(1);
      if (v > SIDE_LIMIT) return SIDE_W'(SIDE_LIMIT);
      return v;
    endfunction

    function void set_size(mma_reg_t r, logic [SIDE_W-1:0] v);
      case (r)
        REG_IMAGE_WIDTH:  sizes.image_width = v;
        REG_IMAGE_HEIGHT: sizes.image_height = v;
        REG_MASK_WIDTH:   sizes.mask_width = v;
        REG_MASK_HEIGHT:  sizes.mask_height = v;
        default: ;
      endcase
    endfunction

    function logic [SIDE_W-1:0] size_of(mma_reg_t r);
      case (r)
        REG_IMAGE_WIDTH:  return sizes.image_width;
        REG_IMAGE_HEIGHT: return sizes.image_height;
        REG_MASK_WIDTH:   return sizes.mask_width;
        default:          return sizes.mask_height;
      endcase
    endfunction

    function int pending();
      return awaited_pixels.size();
    endfunction

    function void predict_alpha(logic [47:0] d);
      logic [CHAN_W-1:0] fr, fg, fb, mr, mg, mb;
      logic [9:0]        front_sum, mask_sum, alpha;
      logic [SIDE_W-1:0] w, h;
      logic              row_end;
      pixel_out_t        p;
      {mb, mg, mr, fb, fg, fr} = d;
      w = clamp_side(sizes.image_width);
      h = clamp_side(sizes.image_height);
      p.mask_used = ({1'b0, column_count} < sizes.mask_width) &&
                    ({1'b0, row_count} < sizes.mask_height);
      if (!p.mask_used) begin
        mr = CHAN_MAX;
        mg = CHAN_MAX;
        mb = CHAN_MAX;
      end
      mask_sum = 10'(mr) + 10'(mg) + 10'(mb);
      front_sum = 10'(fr) + 10'(fg) + 10'(fb);
      alpha = 10'(CHAN_MAX) - mask_sum / 10'd3;
      if (mr > WHITE_LIMIT && mg > WHITE_LIMIT && mb > WHITE_LIMIT) alpha = '0;
      alpha = alpha + front_sum / 10'd3;
      if (alpha > 10'(CHAN_MAX)) alpha = 10'(CHAN_MAX);
      row_end = ({1'b0, column_count} + 13'd1 >= w);
      p.frame_end = row_end && ({1'b0, row_count} + 13'd1 >= h);
      if (row_end) begin
        column_count = '0;
        row_count = p.frame_end ? 12'd0 : row_count + 12'd1;
      end else begin
        column_count = column_count + 12'd1;
      end
      p.red = fr;
      p.green = fg;
      p.blue = fb;
      p.alpha = alpha[CHAN_W-1:0];
      awaited_pixels.push_back(p);
    endfunction

    function void check_pixel(logic [31:0] d, logic used, logic last);
      pixel_out_t e;
      if (awaited_pixels.size() == 0) begin
        complain($sformatf("result %h used %b last %b with no request pending", d, used, last));
        return;
      end
      e = awaited_pixels.pop_front();
      if (d[7:0] !== e.red || d[15:8] !== e.green || d[23:16] !== e.blue ||
          d[31:24] !== e.alpha || used !== e.mask_used || last !== e.frame_end) begin
        complain($sformatf({"expected rgba %h %h %h %h used %b last %b, ",
                            "got %h %h %h %h used %b last %b"},
                           e.red, e.green, e.blue, e.alpha, e.mask_used, e.frame_end,
                           d[7:0], d[15:8], d[23:16], d[31:24], used, last));
      end
    endfunction

    function void check_size(mma_reg_t r, logic [SIDE_W-1:0] v);
      if (v !== size_of(r))
        complain($sformatf("register %s read %h, expected %h", r.name(), v, size_of(r)));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bit          random_on = 1'b0;
  bit          hold_output;
  bit          sender_quiet = 1'b0;
  int unsigned cycles = 0;

  alpha_scoreboard sb = new();

  merge_mask_into_alpha uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.predict_alpha(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [47:0] pack_pixel(int fr, int fg, int fb, int mr, int mg, int mb);
    return {8'(mb), 8'(mg), 8'(mr), 8'(fb), 8'(fg), 8'(fr)};
  endfunction

  function automatic logic [47:0] random_pixel();
    logic [CHAN_W-1:0] f[3];
    logic [CHAN_W-1:0] m[3];
    case ($urandom_range(0, 3))
      0:       for (int k = 0; k < 3; k++) f[k] = 8'($urandom_range(200, 255));
      1:       for (int k = 0; k < 3; k++) f[k] = $urandom_range(0, 1) ? CHAN_MAX : 8'h00;
      default: for (int k = 0; k < 3; k++) f[k] = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < 3; k++) m[k] = 8'($urandom);
      1: for (int k = 0; k < 3; k++) m[k] = 8'($urandom_range(238, 255));
      2: begin
        for (int k = 0; k < 3; k++) m[k] = 8'($urandom_range(241, 255));
        if ($urandom_range(0, 1) == 1) m[$urandom_range(0, 2)] = WHITE_LIMIT;
      end
      default: for (int k = 0; k < 3; k++) m[k] = $urandom_range(0, 1) ? CHAN_MAX : 8'h00;
    endcase
    return {m[2], m[1], m[0], f[2], f[1], f[0]};
  endfunction

  function automatic logic [SIDE_W-1:0] pick_image_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIDE_W'(SIDE_LIMIT);
      2:       return SIDE_W'($urandom_range(SIDE_LIMIT + 1, 8191));
      3:       return SIDE_W'($urandom_range(17, SIDE_LIMIT - 1));
      default: return SIDE_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [SIDE_W-1:0] pick_mask_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIDE_W'(8191);
      2:       return SIDE_W'(SIDE_LIMIT);
      3:       return SIDE_W'($urandom_range(0, 8191));
      default: return SIDE_W'($urandom_range(0, 18));
    endcase
  endfunction

  task automatic apb_write(input mma_reg_t r, input logic [SIDE_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ADDR_W'(4 * int'(r));
    pwdata <= {19'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_size(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input mma_reg_t r);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_ADDR_W'(4 * int'(r));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_size(r, prdata[SIDE_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_sizes(input logic [SIDE_W-1:0] iw, input logic [SIDE_W-1:0] ih,
                             input logic [SIDE_W-1:0] mw, input logic [SIDE_W-1:0] mh,
                             input logic [3:0] which);
    logic [SIDE_W-1:0] vals[4];
    vals[0] = iw;
    vals[1] = ih;
    vals[2] = mw;
    vals[3] = mh;
    for (int i = 0; i < 4; i++) if (which[i]) apb_write(mma_reg_t'(i), vals[i]);
    for (int i = 0; i < 4; i++) if (which[i]) apb_read(mma_reg_t'(i));
  endtask

  // The valid line is lowered only when a gap follows, so back-to-back requests keep it high.
  task automatic send_pixel(input logic [47:0] d);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0 || hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_output) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  // The output is held off for long stretches while requests keep coming, so the queue fills.
  initial begin
    hold_output <= 1'b0;
    wait (random_on);
    repeat (2) begin
      repeat ($urandom_range(10, 40)) @(posedge clk);
      hold_output <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_output <= 1'b0;
      repeat ($urandom_range(2000, 4000)) @(posedge clk);
    end
  end

  initial begin
    int n;
    int random_sent;
    random_sent = 0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Two frames of three by two with a one-row mask; covers saturation and near-white masks.
    apply_sizes(3, 2, 3, 1, 4'hF);
    send_pixel(pack_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(pack_pixel(255, 255, 255, 0, 0, 0));
    send_pixel(pack_pixel(1, 2, 3, 241, 241, 241));
    send_pixel(pack_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(pack_pixel(255, 255, 255, 0, 0, 0));
    send_pixel(pack_pixel(128, 64, 32, 200, 200, 200));
    send_pixel(pack_pixel(0, 0, 0, 240, 241, 241));
    send_pixel(pack_pixel(0, 0, 0, 241, 241, 240));
    send_pixel(pack_pixel(255, 255, 254, 255, 255, 255));
    send_pixel(pack_pixel(255, 0, 255, 17, 99, 250));
    send_pixel(pack_pixel(0, 255, 0, 0, 255, 0));
    send_pixel(pack_pixel(170, 85, 170, 85, 170, 85));
    drain_requests();

    // Zero sizes: every pixel closes a frame and no mask pixel is real.
    apply_sizes(0, 0, 0, 0, 4'hF);
    repeat (4) send_pixel(pack_pixel(255, 255, 255, 0, 0, 0));
    drain_requests();

    // Oversized sides, then a change of size part way through a row.
    apply_sizes(8191, 8191, 8191, 8191, 4'hF);
    send_pixel(pack_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(pack_pixel(255, 255, 255, 255, 255, 255));
    send_pixel(pack_pixel(90, 91, 92, 10, 20, 30));
    drain_requests();
    apply_sizes(4096, 4096, 4096, 0, 4'hF);
    send_pixel(pack_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(pack_pixel(3, 6, 9, 1, 2, 3));
    send_pixel(pack_pixel(255, 128, 1, 0, 0, 0));
    drain_requests();

    while (random_sent < RANDOM_ITEMS) begin
      apply_sizes(pick_image_side(), pick_image_side(), pick_mask_side(), pick_mask_side(),
                  4'($urandom_range(1, 15)));
      random_on <= 1'b1;
      n = $urandom_range(30, 150);
      repeat (n) begin
        if (random_sent % 64 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
        send_pixel(random_pixel());
        random_sent++;
      end
      drain_requests();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
